@@ sv/alc_pkg.sv @@
// Package for the array list with cursor: word types, command codes, defaults.
// No dependencies; imported by alc_ctrl and array_list_with_cursor.
package alc_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int COUNT_OUT_W  = 7;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FIRST  = 2'd1;
  localparam logic [1:0] MODE_NEXT   = 2'd2;
  localparam logic [1:0] MODE_REMOVE = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic                   ok;
    logic signed [31:0]     value_out;
    logic [COUNT_OUT_W-1:0] count;
  } out_word_t;

endpackage

@@ sv/alc_ram.sv @@
// Entry store of the list: one write port, one read port, registered read data.
// Depends on nothing; instantiated by array_list_with_cursor.
module alc_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     wa,
  input  logic [31:0]       wd,
  input  logic [AW-1:0]     ra,
  output logic [31:0]       rd
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

@@ sv/alc_ctrl.sv @@
// Command sequencer of the array list: count, cursor, and the compacting shift loop.
// Depends on alc_pkg; drives the entry store alc_ram.
module alc_ctrl import alc_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IW       = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_vld,
  input  in_word_t      cmd,
  output logic          busy,
  output logic          ram_we,
  output logic [IW-1:0] ram_wa,
  output logic [31:0]   ram_wd,
  output logic [IW-1:0] ram_ra,
  input  logic [31:0]   ram_rd,
  output out_word_t     res,
  output logic          res_vld,
  input  logic          res_take
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_GRAB   = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               cur_vld_r, cur_vld_nxt;
  logic [IW-1:0]      cur_idx_r, cur_idx_nxt;
  logic [IW-1:0]      w_r, w_nxt;
  logic               is_rm_r, is_rm_nxt;
  logic               ok_r, ok_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [CW+6:0]      cnt_ext;
  logic [CW-1:0]      cur_plus1;
  logic [CW-1:0]      w_plus1;

  assign cur_plus1 = CW'(cur_idx_r) + CW'(1);
  assign w_plus1   = CW'(w_r) + CW'(1);
  assign cnt_ext   = {{COUNT_OUT_W{1'b0}}, count_r};

  assign busy      = (state_r != ST_IDLE);
  assign res_vld   = (state_r == ST_FINISH);
  assign res.ok        = ok_r;
  assign res.value_out = val_r;
  assign res.count     = cnt_ext[COUNT_OUT_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cur_vld_nxt = cur_vld_r;
    cur_idx_nxt = cur_idx_r;
    w_nxt       = w_r;
    is_rm_nxt   = is_rm_r;
    ok_nxt      = ok_r;
    val_nxt     = val_r;
    ram_we      = 1'b0;
    ram_wa      = w_r;
    ram_wd      = ram_rd;
    ram_ra      = cur_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_vld) begin
          ok_nxt    = 1'b0;
          val_nxt   = '0;
          is_rm_nxt = 1'b0;
          state_nxt = ST_FINISH;
          unique case (cmd.mode)
            MODE_INSERT: begin
              if (count_r < CW'(CAPACITY)) begin
                ram_we    = 1'b1;
                ram_wa    = count_r[IW-1:0];
                ram_wd    = cmd.value_in;
                count_nxt = count_r + CW'(1);
                ok_nxt    = 1'b1;
              end
            end
            MODE_FIRST: begin
              if (count_r != '0) begin
                ram_ra      = '0;
                cur_vld_nxt = 1'b1;
                cur_idx_nxt = '0;
                ok_nxt      = 1'b1;
                state_nxt   = ST_GRAB;
              end
            end
            MODE_NEXT: begin
              if (!cur_vld_r) begin
                if (count_r != '0) begin
                  ram_ra      = '0;
                  cur_vld_nxt = 1'b1;
                  cur_idx_nxt = '0;
                  ok_nxt      = 1'b1;
                  state_nxt   = ST_GRAB;
                end
              end else if (cur_plus1 < count_r) begin
                ram_ra      = cur_plus1[IW-1:0];
                cur_idx_nxt = cur_plus1[IW-1:0];
                ok_nxt      = 1'b1;
                state_nxt   = ST_GRAB;
              end
            end
            MODE_REMOVE: begin
              if (cur_vld_r && (CW'(cur_idx_r) < count_r)) begin
                ram_ra    = cur_idx_r;
                w_nxt     = cur_idx_r;
                is_rm_nxt = 1'b1;
                ok_nxt    = 1'b1;
                state_nxt = ST_GRAB;
              end
            end
            default: ;
          endcase
        end
      end
      ST_GRAB: begin
        val_nxt   = ram_rd;
        state_nxt = ST_FINISH;
        if (is_rm_r) begin
          ram_ra    = w_plus1[IW-1:0];
          count_nxt = count_r - CW'(1);
          if (cur_idx_r == '0) begin
            cur_vld_nxt = 1'b0;
          end else begin
            cur_idx_nxt = cur_idx_r - IW'(1);
          end
          if (w_plus1 < count_r) begin
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        // write entry w from the word read last cycle, fetch the one after
        ram_we = 1'b1;
        ram_wa = w_r;
        ram_wd = ram_rd;
        ram_ra = w_r + IW'(2);
        w_nxt  = w_plus1[IW-1:0];
        if (!(w_plus1 < count_r)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      cur_vld_r <= 1'b0;
      is_rm_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cur_vld_r <= cur_vld_nxt;
      is_rm_r   <= is_rm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx_r <= cur_idx_nxt;
    w_r       <= w_nxt;
    ok_r      <= ok_nxt;
    val_r     <= val_nxt;
  end

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("stored count beyond capacity");

  a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (CW'(cur_idx_r) < count_r))
    else $error("cursor points past the stored entries");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (CW'(w_r) < count_r))
    else $error("shift source beyond stored entries");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && cmd_vld) |=> busy)
    else $error("command taken but sequencer stayed idle");

  a_take_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> (state_r == ST_FINISH))
    else $error("result taken while none pending");

endmodule

@@ sv/array_list_with_cursor.sv @@
// Top level of the array list with cursor: sequencer, entry store, output register.
// Depends on alc_pkg, alc_ram and alc_ctrl.
//
// Input channel in_valid/in_stall/in_data carries one command word: mode (insert,
// first, next, remove at cursor) and value_in for insert. Output channel
// out_valid/out_stall/out_data returns one result word per command: ok, value_out
// and the stored count after the command. A word moves at a clock edge where valid
// is high and stall is low.
// One command at a time: in_stall is high from acceptance until its result is
// loaded into the output register. Insert and any failed command go straight to
// the result; first, next and a remove of the last entry read the store once
// before it; a remove that compacts the list then also moves the entries after the
// cursor down by one (count - 1 - cursor of them, count before the remove); the
// shift loop moves one entry per cycle through the single store port pair.
// A finished result waits in the sequencer while the output register is held by
// out_stall; the next command is taken the cycle after the result is loaded.
// Reset (rst_n low, synchronous) empties the list and clears the cursor; the entry
// store needs no clearing pass.
module array_list_with_cursor import alc_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          ram_we;
  logic [IW-1:0] ram_wa;
  logic [31:0]   ram_wd;
  logic [IW-1:0] ram_ra;
  logic [31:0]   ram_rd;
  out_word_t     res;
  logic          res_vld;
  logic          res_take;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_data_r;

  alc_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_vld  (in_valid),
    .cmd      (in_data),
    .busy     (in_stall),
    .ram_we   (ram_we),
    .ram_wa   (ram_wa),
    .ram_wd   (ram_wd),
    .ram_ra   (ram_ra),
    .ram_rd   (ram_rd),
    .res      (res),
    .res_vld  (res_vld),
    .res_take (res_take)
  );

  alc_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  assign res_take = res_vld && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
